@@ rtl/core/bgr_pkg.sv @@
// Shared types and constants of the bilinear grid resampler.
// Used by the top level, the pipelined divider and the port checker.
// No dependencies.
package bgr_pkg;

    localparam int COORD_W    = 40;    // Q31.8 coordinates
    localparam int CELL_W     = 24;    // Q16.8 cell size
    localparam int SAMP_W     = 32;    // Q15.16 samples
    localparam int FRAC_W     = 16;    // weight fraction bits
    localparam int FRAC_ONE   = 65536; // weight of one
    localparam int IDX_W      = 14;    // load index width
    localparam int GRID_W     = 8;     // grid_cols / grid_rows registers
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int S_TDATA_W  = 160;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INTERP  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_CORNER  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEST   = 3'd0,
        CFG_SOUTH  = 3'd1,
        CFG_CELL   = 3'd2,
        CFG_COLS   = 3'd3,
        CFG_ROWS   = 3'd4,
        CFG_MARKER = 3'd5,
        CFG_AUX    = 3'd6
    } cfg_idx_t;

endpackage

@@ rtl/core/bilinear_grid_resampler.sv @@
// Bilinear grid resampler, top level.
// Depends on bgr_pkg and bgr_div; the port checker binds to it.
//
// Fully pipelined: one transaction (load or query) is accepted every clock and
// each query returns exactly one result transaction. A bit-per-stage divider
// finds the cell and its weights. Loads travel the same pipeline and write the
// sample stores at the stage where queries read them, so loads and queries act
// in the order they arrive. The whole pipeline holds while a result waits at
// the output and m_tready is low; s_tready then drops. The stores hold random
// data until loaded. Configuration writes are taken whenever cfg_wr_en is high
// and must be made while no transaction is in flight.
module bilinear_grid_resampler #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [bgr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [13:0] load_index, [45:14] load_depth, [77:46] load_aux,
    // [117:78] query_east, [157:118] query_north, [159:158] zero
    input  logic [bgr_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] operation
    input  logic [bgr_pkg::S_TUSER_W-1:0]      s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] depth_out, [63:32] aux_out
    output logic [bgr_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [bgr_pkg::M_TUSER_W-1:0]      m_tuser
);
    import bgr_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int QW    = (CW > RW) ? CW : RW;
    localparam int NS    = QW + FRAC_W;
    localparam int DW    = CELL_W + QW;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ECW   = CW + 1;
    localparam int ERW   = RW + 1;
    localparam int SPX_W = ECW + CELL_W;
    localparam int SPY_W = ERW + CELL_W;
    localparam int PW    = 2 * SAMP_W + 2;   // product and sum width

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [SAMP_W-1:0] dep;
        logic [SAMP_W-1:0] aux;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  in_grid;
    } trk_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] west_reg;
    logic signed [COORD_W-1:0] south_reg;
    logic [CELL_W-1:0]         cell_reg;
    logic [GRID_W-1:0]         cols_reg;
    logic [GRID_W-1:0]         rows_reg;
    logic [SAMP_W-1:0]         marker_reg;
    logic                      aux_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            west_reg   <= '0;
            south_reg  <= '0;
            cell_reg   <= CELL_W'(256);
            cols_reg   <= GRID_W'(128);
            rows_reg   <= GRID_W'(128);
            marker_reg <= '0;
            aux_on_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_WEST:   west_reg   <= cfg_wdata[COORD_W-1:0];
                CFG_SOUTH:  south_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_CELL:   cell_reg   <= cfg_wdata[CELL_W-1:0];
                CFG_COLS:   cols_reg   <= cfg_wdata[GRID_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_wdata[GRID_W-1:0];
                CFG_MARKER: marker_reg <= cfg_wdata[SAMP_W-1:0];
                CFG_AUX:    aux_on_reg <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // Effective grid size and cell size: saturate the grid to [2, MAX],
    // treat a zero cell size as one.
    logic [ECW-1:0]    ec;
    logic [ERW-1:0]    er;
    logic [CELL_W-1:0] cs;

    always_comb begin
        if (cols_reg < GRID_W'(2))
            ec = ECW'(2);
        else if (32'(cols_reg) > 32'(MAX_COLS))
            ec = ECW'(MAX_COLS);
        else
            ec = ECW'(cols_reg);
        if (rows_reg < GRID_W'(2))
            er = ERW'(2);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            er = ERW'(MAX_ROWS);
        else
            er = ERW'(rows_reg);
        cs = (cell_reg == '0) ? CELL_W'(1) : cell_reg;
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances together
    // ------------------------------------------------------------------
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: capture the transaction
    // ------------------------------------------------------------------
    item_t                     in_item;
    logic                      s1_v_reg;
    item_t                     s1_item_reg;
    logic signed [COORD_W-1:0] s1_east_reg;
    logic signed [COORD_W-1:0] s1_north_reg;

    assign in_item.op  = op_t'(s_tuser[0]);
    assign in_item.idx = s_tdata[13:0];
    assign in_item.dep = s_tdata[45:14];
    assign in_item.aux = s_tdata[77:46];

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg  <= in_item;
            s1_east_reg  <= s_tdata[117:78];
            s1_north_reg <= s_tdata[157:118];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: grid spans and offsets from the edges
    // ------------------------------------------------------------------
    logic                      s2_v_reg;
    item_t                     s2_item_reg;
    logic [SPX_W-1:0]          span_x_reg;
    logic [SPY_W-1:0]          span_y_reg;
    logic signed [COORD_W:0]   dx_reg;
    logic signed [COORD_W:0]   dn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_item_reg <= s1_item_reg;
            span_x_reg  <= SPX_W'(ec - ECW'(1)) * SPX_W'(cs);
            span_y_reg  <= SPY_W'(er - ERW'(1)) * SPY_W'(cs);
            dx_reg      <= (COORD_W+1)'(s1_east_reg) - (COORD_W+1)'(west_reg);
            dn_reg      <= (COORD_W+1)'(s1_north_reg) - (COORD_W+1)'(south_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: strict extent test, offsets into the divider
    // ------------------------------------------------------------------
    logic signed [COORD_W:0] spx_s;
    logic signed [COORD_W:0] spy_s;
    logic signed [COORD_W:0] oy_full;
    logic                    inside_next;
    logic                    s3_v_reg;
    trk_t                    s3_trk_reg;
    logic [DW-1:0]           ox_reg;
    logic [DW-1:0]           oy_reg;

    always_comb begin
        spx_s       = $signed((COORD_W+1)'(span_x_reg));
        spy_s       = $signed((COORD_W+1)'(span_y_reg));
        oy_full     = spy_s - dn_reg;
        inside_next = (dx_reg > 0) && (dx_reg < spx_s) && (dn_reg > 0) && (dn_reg < spy_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_trk_reg.item    <= s2_item_reg;
            s3_trk_reg.in_grid <= inside_next;
            ox_reg             <= dx_reg[DW-1:0];
            oy_reg             <= oy_full[DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: column/row and weight fractions in one pass
    // ------------------------------------------------------------------
    logic [NS-1:0] qx;
    logic [NS-1:0] qy;
    logic          nz_y;
    logic          dl_v_reg   [NS];
    trk_t          dl_trk_reg [NS];

    bgr_div #(.QW(QW)) u_div_x (
        .aclk     (aclk),
        .en       (en),
        .divisor  (cs),
        .dividend (ox_reg),
        .quotient (qx),
        .rem_nz   ()
    );

    bgr_div #(.QW(QW)) u_div_y (
        .aclk     (aclk),
        .en       (en),
        .divisor  (cs),
        .dividend (oy_reg),
        .quotient (qy),
        .rem_nz   (nz_y)
    );

    // Carry the transaction alongside the divider.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++)
                dl_v_reg[k] <= 1'b0;
        end else if (en) begin
            dl_v_reg[0] <= s3_v_reg;
            for (int k = 1; k < NS; k++)
                dl_v_reg[k] <= dl_v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_trk_reg[0] <= s3_trk_reg;
            for (int k = 1; k < NS; k++)
                dl_trk_reg[k] <= dl_trk_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Address stage 1: row base and axis weights
    // ------------------------------------------------------------------
    logic [QW-1:0]     col_q;
    logic [QW-1:0]     row_q;
    logic              a1_v_reg;
    trk_t              a1_trk_reg;
    logic [AW-1:0]     a1_row_reg;
    logic [QW-1:0]     a1_col_reg;
    logic [FRAC_W:0]   a1_wx_reg;
    logic [FRAC_W:0]   a1_wy_reg;

    assign col_q = qx[NS-1:FRAC_W];
    assign row_q = qy[NS-1:FRAC_W];

    always_ff @(posedge aclk) begin
        if (!aresetn)
            a1_v_reg <= 1'b0;
        else if (en)
            a1_v_reg <= dl_v_reg[NS-1];
    end

    // wy = one minus the rounded-up northward fraction
    always_ff @(posedge aclk) begin
        if (en) begin
            a1_trk_reg <= dl_trk_reg[NS-1];
            a1_row_reg <= AW'((QW+ECW)'(row_q) * (QW+ECW)'(ec));
            a1_col_reg <= col_q;
            a1_wx_reg  <= (FRAC_W+1)'(qx[FRAC_W-1:0]);
            a1_wy_reg  <= (FRAC_W+1)'(FRAC_ONE) - (FRAC_W+1)'(qy[FRAC_W-1:0])
                          - (FRAC_W+1)'(nz_y);
        end
    end

    // ------------------------------------------------------------------
    // Address stage 2: corner addresses and corner weights
    // ------------------------------------------------------------------
    logic [FRAC_W:0] nx_w;
    logic [FRAC_W:0] ny_w;
    logic            a2_v_reg;
    trk_t            a2_trk_reg;
    logic [AW-1:0]   a2_addr_reg [4];
    logic [32:0]     a2_w_reg    [4];

    assign nx_w = (FRAC_W+1)'(FRAC_ONE) - a1_wx_reg;
    assign ny_w = (FRAC_W+1)'(FRAC_ONE) - a1_wy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            a2_v_reg <= 1'b0;
        else if (en)
            a2_v_reg <= a1_v_reg;
    end

    // Corners in order: (r,c), (r,c+1), (r+1,c), (r+1,c+1)
    always_ff @(posedge aclk) begin
        if (en) begin
            a2_trk_reg     <= a1_trk_reg;
            a2_addr_reg[0] <= AW'((AW+1)'(a1_row_reg) + (AW+1)'(a1_col_reg));
            a2_addr_reg[1] <= AW'((AW+1)'(a1_row_reg) + (AW+1)'(a1_col_reg) + (AW+1)'(1));
            a2_addr_reg[2] <= AW'((AW+1)'(a1_row_reg) + (AW+1)'(ec) + (AW+1)'(a1_col_reg));
            a2_addr_reg[3] <= AW'((AW+1)'(a1_row_reg) + (AW+1)'(ec) + (AW+1)'(a1_col_reg)
                              + (AW+1)'(1));
            a2_w_reg[0]    <= 33'(34'(nx_w) * 34'(a1_wy_reg));
            a2_w_reg[1]    <= 33'(34'(a1_wx_reg) * 34'(a1_wy_reg));
            a2_w_reg[2]    <= 33'(34'(nx_w) * 34'(ny_w));
            a2_w_reg[3]    <= 33'(34'(a1_wx_reg) * 34'(ny_w));
        end
    end

    // ------------------------------------------------------------------
    // Store stage: loads write, queries read four corners of each channel.
    // Each channel is held twice so that each copy serves two read addresses.
    // ------------------------------------------------------------------
    logic [SAMP_W-1:0] dep_n_mem [DEPTH];
    logic [SAMP_W-1:0] dep_s_mem [DEPTH];
    logic [SAMP_W-1:0] aux_n_mem [DEPTH];
    logic [SAMP_W-1:0] aux_s_mem [DEPTH];
    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic              m_q_reg;
    logic              m_inside_reg;
    logic [32:0]       m_w_reg [4];
    logic [SAMP_W-1:0] m_d_reg [4];
    logic [SAMP_W-1:0] m_a_reg [4];

    assign wr_ok   = a2_v_reg && (a2_trk_reg.item.op == OP_LOAD)
                     && (32'(a2_trk_reg.item.idx) < 32'(DEPTH));
    assign wr_addr = AW'(a2_trk_reg.item.idx);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_ok) begin
                dep_n_mem[wr_addr] <= a2_trk_reg.item.dep;
                dep_s_mem[wr_addr] <= a2_trk_reg.item.dep;
                aux_n_mem[wr_addr] <= a2_trk_reg.item.aux;
                aux_s_mem[wr_addr] <= a2_trk_reg.item.aux;
            end
            m_d_reg[0] <= dep_n_mem[a2_addr_reg[0]];
            m_d_reg[1] <= dep_n_mem[a2_addr_reg[1]];
            m_d_reg[2] <= dep_s_mem[a2_addr_reg[2]];
            m_d_reg[3] <= dep_s_mem[a2_addr_reg[3]];
            m_a_reg[0] <= aux_n_mem[a2_addr_reg[0]];
            m_a_reg[1] <= aux_n_mem[a2_addr_reg[1]];
            m_a_reg[2] <= aux_s_mem[a2_addr_reg[2]];
            m_a_reg[3] <= aux_s_mem[a2_addr_reg[3]];
        end
    end

    // From here on only queries matter; drop loads.
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_q_reg <= 1'b0;
        else if (en)
            m_q_reg <= a2_v_reg && (a2_trk_reg.item.op == OP_QUERY);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_inside_reg <= a2_trk_reg.in_grid;
            for (int k = 0; k < 4; k++)
                m_w_reg[k] <= a2_w_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Product stage: weight each corner, test depth corners for the marker
    // ------------------------------------------------------------------
    logic                 p_q_reg;
    logic                 p_inside_reg;
    logic                 p_bad_reg;
    logic signed [PW-1:0] p_pd_reg [4];
    logic signed [PW-1:0] p_pa_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn)
            p_q_reg <= 1'b0;
        else if (en)
            p_q_reg <= m_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_inside_reg <= m_inside_reg;
            p_bad_reg    <= (m_d_reg[0] == marker_reg) || (m_d_reg[1] == marker_reg)
                            || (m_d_reg[2] == marker_reg) || (m_d_reg[3] == marker_reg);
            for (int k = 0; k < 4; k++) begin
                p_pd_reg[k] <= PW'($signed(m_d_reg[k])) * PW'($signed({1'b0, m_w_reg[k]}));
                p_pa_reg[k] <= PW'($signed(m_a_reg[k])) * PW'($signed({1'b0, m_w_reg[k]}));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum stages: pairs, then the total
    // ------------------------------------------------------------------
    logic                 s_q_reg;
    logic                 s_inside_reg;
    logic                 s_bad_reg;
    logic signed [PW-1:0] s_d01_reg;
    logic signed [PW-1:0] s_d23_reg;
    logic signed [PW-1:0] s_a01_reg;
    logic signed [PW-1:0] s_a23_reg;
    logic                 t_q_reg;
    logic                 t_inside_reg;
    logic                 t_bad_reg;
    logic signed [PW-1:0] t_dacc_reg;
    logic signed [PW-1:0] t_aacc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_q_reg <= 1'b0;
            t_q_reg <= 1'b0;
        end else if (en) begin
            s_q_reg <= p_q_reg;
            t_q_reg <= s_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_inside_reg <= p_inside_reg;
            s_bad_reg    <= p_bad_reg;
            s_d01_reg    <= p_pd_reg[0] + p_pd_reg[1];
            s_d23_reg    <= p_pd_reg[2] + p_pd_reg[3];
            s_a01_reg    <= p_pa_reg[0] + p_pa_reg[1];
            s_a23_reg    <= p_pa_reg[2] + p_pa_reg[3];
            t_inside_reg <= s_inside_reg;
            t_bad_reg    <= s_bad_reg;
            t_dacc_reg   <= s_d01_reg + s_d23_reg;
            t_aacc_reg   <= s_a01_reg + s_a23_reg;
        end
    end

    // Divide by 2^32, truncating toward zero: bias negatives before the shift.
    function automatic logic [SAMP_W-1:0] trunc_q32(input logic signed [PW-1:0] acc);
        logic [PW-1:0] biased;
        biased = acc + (acc[PW-1] ? {{(PW-32){1'b0}}, 32'hFFFF_FFFF} : {PW{1'b0}});
        return biased[63:32];
    endfunction

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SAMP_W-1:0] depth_next;
    logic [SAMP_W-1:0] aux_next;
    status_t           status_next;
    logic [SAMP_W-1:0] m_depth_reg;
    logic [SAMP_W-1:0] m_aux_reg;
    status_t           m_status_reg;

    always_comb begin
        if (!t_inside_reg) begin
            status_next = ST_OUTSIDE;
            depth_next  = marker_reg;
            aux_next    = marker_reg;
        end else if (t_bad_reg) begin
            status_next = ST_CORNER;
            depth_next  = marker_reg;
            aux_next    = marker_reg;
        end else begin
            status_next = ST_INTERP;
            depth_next  = trunc_q32(t_dacc_reg);
            aux_next    = aux_on_reg ? trunc_q32(t_aacc_reg) : marker_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= t_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_depth_reg  <= depth_next;
            m_aux_reg    <= aux_next;
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_aux_reg, m_depth_reg};
    assign m_tuser  = m_status_reg;

endmodule

@@ rtl/core/bgr_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Yields floor(dividend * 2^16 / divisor) and a non-zero-remainder flag.
// Depends on bgr_pkg.
module bgr_div #(
    parameter int QW = 7
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [bgr_pkg::CELL_W-1:0]          divisor,
    input  logic [bgr_pkg::CELL_W+QW-1:0]       dividend,
    output logic [QW+bgr_pkg::FRAC_W-1:0]       quotient,
    output logic                                rem_nz
);
    import bgr_pkg::*;

    localparam int DW = CELL_W + QW;
    localparam int QT = QW + FRAC_W;
    localparam int NS = QT;

    logic [DW:0]   rem_reg  [NS];
    logic [DW:0]   rem_next [NS];
    logic [QT-1:0] quo_reg  [NS];
    logic [QT-1:0] quo_next [NS];

    // Integer bits first (compare against shifted divisor), then fraction bits.
    always_comb begin : steps
        logic [DW:0]   src;
        logic [DW:0]   cand;
        logic [DW:0]   sub;
        logic [QT-1:0] qsrc;
        logic          ge;
        for (int j = 0; j < NS; j++) begin
            if (j == 0) begin
                src  = (DW+1)'(dividend);
                qsrc = '0;
            end else begin
                src  = rem_reg[j-1];
                qsrc = quo_reg[j-1];
            end
            if (j < QW) begin
                cand = src;
                sub  = (DW+1)'(divisor) << (QW - 1 - j);
            end else begin
                cand = src << 1;
                sub  = (DW+1)'(divisor);
            end
            ge          = (cand >= sub);
            rem_next[j] = ge ? (cand - sub) : cand;
            quo_next[j] = {qsrc[QT-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NS; j++) begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign quotient = quo_reg[NS-1];
    assign rem_nz   = |rem_reg[NS-1];

endmodule

@@ rtl/core/bgr_checker.sv @@
// Port-level checker for the bilinear grid resampler, bound to the top level.
// Depends on bgr_pkg.
module bgr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bgr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bgr_pkg::M_TUSER_W-1:0] m_tuser
);
    import bgr_pkg::*;

    // A held result must block new input.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while a result is held");

    // Outside and corner-invalid results carry the marker on both channels.
    a_marker_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_INTERP) |-> m_tdata[63:32] == m_tdata[31:0])
        else $error("non-interpolated result with differing channels");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the output.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bilinear_grid_resampler bgr_checker u_bgr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
